/* src/polarization_stokes_pixel_unit_macros.svh */
// Assertion macros shared by the polarization Stokes pixel unit.
`ifndef POLARIZATION_STOKES_PIXEL_UNIT_MACROS_SVH
`define POLARIZATION_STOKES_PIXEL_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i and disabled during reset.
`define PSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled during reset.
`define PSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/psp_pkg.sv */
// Types, constants and table functions of the polarization Stokes pixel unit.
package psp_pkg;

  // Output mode codes.
  typedef enum logic [1:0] {
    MODE_ANGLE  = 2'd0,
    MODE_DEGREE = 2'd1,
    MODE_HSV    = 2'd2,
    MODE_QUAD   = 2'd3
  } mode_e;

  // Configuration register indexes.
  localparam logic [7:0] CFG_OUTPUT_MODE  = 8'd0;
  localparam logic [7:0] CFG_SAMPLE_DEPTH = 8'd1;
  localparam logic [7:0] CFG_GAIN_0       = 8'd2;
  localparam logic [7:0] CFG_GAIN_45      = 8'd3;
  localparam logic [7:0] CFG_GAIN_90      = 8'd4;
  localparam logic [7:0] CFG_GAIN_135     = 8'd5;

  // Sample depth codes.
  localparam logic [1:0] DEPTH_8  = 2'd0;
  localparam logic [1:0] DEPTH_12 = 2'd1;

  // Reset values of the calibration gains (unsigned Q2.14).
  localparam logic [15:0] GAIN_0_RST   = 16'd16825;
  localparam logic [15:0] GAIN_45_RST  = 16'd16384;
  localparam logic [15:0] GAIN_90_RST  = 16'd17015;
  localparam logic [15:0] GAIN_135_RST = 16'd16466;

  // Degree scaling: 255 * 4000 on the Q.12 magnitude, 1000 * stk0 + 2^14 below.
  localparam int unsigned DEG_SCALE = 1020000;
  localparam int unsigned DEN_SCALE = 1000;
  localparam int unsigned DEN_BIAS  = 16384;

  // Quotient bits of the degree divider: eight result bits and one overflow bit.
  localparam int unsigned DIV_STEPS = 9;

  typedef struct packed {
    logic [15:0] pix_90;
    logic [15:0] pix_45;
    logic [15:0] pix_135;
    logic [15:0] pix_0;
  } psp_in_t;

  typedef struct packed {
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic [7:0] byte_c;
    logic [7:0] byte_d;
    logic [2:0] bytes_used;
  } psp_out_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } rgb_t;

  // Arctangent of 2^-i in units of 2^-32 turn, truncated.
  function automatic logic [31:0] cordic_atan(input int unsigned i);
    logic [31:0] a;
    unique case (i)
      0:  a = 32'h20000000;
      1:  a = 32'h12E4051D;
      2:  a = 32'h09FB385B;
      3:  a = 32'h051111D4;
      4:  a = 32'h028B0D43;
      5:  a = 32'h0145D7E1;
      6:  a = 32'h00A2F61E;
      7:  a = 32'h00517C55;
      8:  a = 32'h0028BE53;
      9:  a = 32'h00145F2E;
      10: a = 32'h000A2F98;
      11: a = 32'h000517CC;
      12: a = 32'h00028BE6;
      13: a = 32'h000145F3;
      14: a = 32'h0000A2F9;
      15: a = 32'h0000517C;
      16: a = 32'h000028BE;
      17: a = 32'h0000145F;
      18: a = 32'h00000A2F;
      19: a = 32'h00000517;
      20: a = 32'h0000028B;
      21: a = 32'h00000145;
      22: a = 32'h000000A2;
      default: a = 32'h00000051;
    endcase
    return a;
  endfunction

  // 256-step hue ramp with a step of six per index.
  function automatic rgb_t hue_ramp(input logic [7:0] k);
    rgb_t c;
    int   ki;
    ki = int'(k);
    c  = '0;
    if (ki <= 42) begin
      c.r = 8'd255;
      c.g = 8'(6 * ki);
    end else if (ki <= 85) begin
      c.r = 8'(252 - 6 * (ki - 43));
      c.g = 8'd255;
    end else if (ki <= 127) begin
      c.g = 8'd255;
      c.b = 8'(6 * (ki - 85));
    end else if (ki <= 170) begin
      c.g = 8'(252 - 6 * (ki - 128));
      c.b = 8'd255;
    end else if (ki <= 212) begin
      c.r = 8'(6 * (ki - 170));
      c.b = 8'd255;
    end else begin
      c.r = 8'd255;
      c.b = 8'(252 - 6 * (ki - 213));
    end
    return c;
  endfunction

endpackage

/* src/polarization_stokes_pixel_unit.sv */
// Top level of the polarization Stokes pixel unit.
// The unit takes one 2x2 polarizer group per clock while the output is not stalled and returns one result per group.
// The result is presented once the group has passed every stage (RB = SAMPLE_BITS + 15
// root bits); the depth is set by the magnitude path: four front stages, a chain of
// RB square root cells, one per root bit, then the divider setup stage and nine
// divider cells for the degree byte, and the output register.
// The angle CORDIC runs beside it in CORDIC_STAGES cells and is delayed to match.
// Every stage advances whenever the output register is empty or being taken, so while
// results are taken the sustained rate is one group per clock with no gaps.
module polarization_stokes_pixel_unit import psp_pkg::*; #(
  parameter int unsigned SAMPLE_BITS   = 16,
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  psp_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output psp_out_t    out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  `include "polarization_stokes_pixel_unit_macros.svh"

  // Data widths.
  localparam int unsigned WW  = SAMPLE_BITS + 16;  // weighted sample
  localparam int unsigned SW  = WW + 1;            // pair sum, Stokes difference
  localparam int unsigned MW  = WW - 2;            // magnitude operand
  localparam int unsigned VW  = 2 * MW + 1;        // sum of squares
  localparam int unsigned RB  = (VW + 1) / 2;      // root bits
  localparam int unsigned NW  = RB + 20;           // degree numerator
  localparam int unsigned DW  = SW + 10;           // degree denominator
  localparam int unsigned XW  = WW + 4;            // CORDIC vector

  // Stage numbers: stage 1 is the register fed by the input transaction.
  localparam int unsigned S_SQ_END = 4 + RB;
  localparam int unsigned S_NUM    = S_SQ_END + 1;
  localparam int unsigned S_DEG    = S_NUM + DIV_STEPS;
  localparam int unsigned Z_DEPTH  = S_DEG - 3 - CORDIC_STAGES;

  // Configuration registers.
  logic [1:0]  mode_q, depth_q;
  logic [15:0] g0_q, g45_q, g90_q, g135_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_ANGLE;
      depth_q <= DEPTH_8;
      g0_q    <= GAIN_0_RST;
      g45_q   <= GAIN_45_RST;
      g90_q   <= GAIN_90_RST;
      g135_q  <= GAIN_135_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_OUTPUT_MODE:  mode_q  <= cfg_data_i[1:0];
        CFG_SAMPLE_DEPTH: depth_q <= cfg_data_i[1:0];
        CFG_GAIN_0:       g0_q    <= cfg_data_i;
        CFG_GAIN_45:      g45_q   <= cfg_data_i;
        CFG_GAIN_90:      g90_q   <= cfg_data_i;
        CFG_GAIN_135:     g135_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Global advance: the output register is free or is being read.
  logic out_valid_q;
  logic en;
  logic [S_DEG-1:0] valid_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      valid_q     <= {valid_q[S_DEG-2:0], in_valid_i};
      out_valid_q <= valid_q[S_DEG-1];
    end
  end

  // Stage 1: sample masking, calibration gains and quad bytes.
  logic [SAMPLE_BITS-1:0] p90, p45, p135, p0;
  logic [3:0]             qsh;
  logic [WW-1:0]          w0_q, w45_q, w90_q, w135_q;
  logic [31:0]            quad_q;

  assign p90  = in_data_i.pix_90[SAMPLE_BITS-1:0];
  assign p45  = in_data_i.pix_45[SAMPLE_BITS-1:0];
  assign p135 = in_data_i.pix_135[SAMPLE_BITS-1:0];
  assign p0   = in_data_i.pix_0[SAMPLE_BITS-1:0];
  assign qsh  = (depth_q == DEPTH_8) ? 4'd0 : (depth_q == DEPTH_12) ? 4'd4 : 4'd8;

  always_ff @(posedge clk_i) begin
    if (en) begin
      w0_q   <= WW'(g0_q) * WW'(p0);
      w45_q  <= WW'(g45_q) * WW'(p45);
      w90_q  <= WW'(g90_q) * WW'(p90);
      w135_q <= WW'(g135_q) * WW'(p135);
      quad_q <= {8'(16'(p90) >> qsh), 8'(16'(p45) >> qsh),
                 8'(16'(p135) >> qsh), 8'(16'(p0) >> qsh)};
    end
  end

  // Stage 2: Stokes terms and the magnitude operands.
  logic [SW-1:0]        sa, sb, stk0_q;
  logic signed [SW-1:0] d1, d2, stk1_q, stk2_q;
  logic [SW-1:0]        a1, a2;
  logic [MW-1:0]        m1_q, m2_q;

  assign sa = SW'(w0_q) + SW'(w90_q);
  assign sb = SW'(w45_q) + SW'(w135_q);
  assign d1 = $signed(SW'(w0_q)) - $signed(SW'(w90_q));
  assign d2 = $signed(SW'(w45_q)) - $signed(SW'(w135_q));
  assign a1 = d1[SW-1] ? SW'(-d1) : SW'(d1);
  assign a2 = d2[SW-1] ? SW'(-d2) : SW'(d2);

  always_ff @(posedge clk_i) begin
    if (en) begin
      stk0_q <= (sa > sb) ? sa : sb;
      stk1_q <= d1;
      stk2_q <= d2;
      m1_q   <= a1[WW-1:2];
      m2_q   <= a2[WW-1:2];
    end
  end

  // Stage 3: squares, and CORDIC folding into the right half plane.
  logic [2*MW-1:0]      sq1_q, sq2_q;
  logic signed [XW-1:0] cx [CORDIC_STAGES+1];
  logic signed [XW-1:0] cy [CORDIC_STAGES+1];
  logic [31:0]          cz [CORDIC_STAGES+1];
  logic signed [XW-1:0] x_ext, y_ext;
  logic [1:0]           horiz_q, horiz_dly;

  assign x_ext = XW'(stk1_q);
  assign y_ext = XW'(stk2_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq1_q   <= (2*MW)'(m1_q) * (2*MW)'(m1_q);
      sq2_q   <= (2*MW)'(m2_q) * (2*MW)'(m2_q);
      horiz_q <= {stk2_q == '0, stk1_q[SW-1]};
      if (stk1_q[SW-1]) begin
        cx[0] <= -x_ext;
        cy[0] <= -y_ext;
        cz[0] <= 32'h80000000;
      end else begin
        cx[0] <= x_ext;
        cy[0] <= y_ext;
        cz[0] <= 32'h0;
      end
    end
  end

  // CORDIC rotation chain.
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    psp_cordic_cell #(.XW(XW), .STAGE(i)) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .x_i   (cx[i]),
      .y_i   (cy[i]),
      .z_i   (cz[i]),
      .x_o   (cx[i+1]),
      .y_o   (cy[i+1]),
      .z_o   (cz[i+1])
    );
  end

  psp_delay #(.WIDTH(2), .DEPTH(CORDIC_STAGES)) u_horiz_dly (
    .clk_i  (clk_i),
    .en_i   (en),
    .data_i (horiz_q),
    .data_o (horiz_dly)
  );

  // A purely horizontal vector gives zero or half a turn directly.
  logic [31:0] z_fin, z_al;

  assign z_fin = horiz_dly[1] ? {horiz_dly[0], 31'b0} : cz[CORDIC_STAGES];

  psp_delay #(.WIDTH(32), .DEPTH(Z_DEPTH)) u_z_dly (
    .clk_i  (clk_i),
    .en_i   (en),
    .data_i (z_fin),
    .data_o (z_al)
  );

  // Stage 4: sum of squares.
  logic [VW-1:0] rem [RB+1];
  logic [RB-1:0] root [RB+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      rem[0]  <= VW'(sq1_q) + VW'(sq2_q);
      root[0] <= '0;
    end
  end

  // Square root chain, most significant root bit first.
  for (genvar j = 0; j < RB; j++) begin : g_sqrt
    psp_sqrt_cell #(.VW(VW), .RB(RB), .BIT(RB - 1 - j)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .rem_i  (rem[j]),
      .root_i (root[j]),
      .rem_o  (rem[j+1]),
      .root_o (root[j+1])
    );
  end

  // Intensity travels beside the root chain.
  logic [SW-1:0] stk0_dly;

  psp_delay #(.WIDTH(SW), .DEPTH(S_SQ_END - 2)) u_stk0_dly (
    .clk_i  (clk_i),
    .en_i   (en),
    .data_i (stk0_q),
    .data_o (stk0_dly)
  );

  // Numerator and denominator of the degree.
  logic [NW-1:0]        drem [DIV_STEPS+1];
  logic [DW-1:0]        dden [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] dq   [DIV_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      drem[0] <= NW'(root[RB]) * NW'(DEG_SCALE);
      dden[0] <= DW'(stk0_dly) * DW'(DEN_SCALE) + DW'(DEN_BIAS);
      dq[0]   <= '0;
    end
  end

  // Divider chain; its first cell flags a quotient of 256 or more.
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    psp_div_cell #(.NW(NW), .DW(DW), .BIT(DIV_STEPS - 1 - k)) u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .rem_i (drem[k]),
      .den_i (dden[k]),
      .q_i   (dq[k]),
      .rem_o (drem[k+1]),
      .den_o (dden[k+1]),
      .q_o   (dq[k+1])
    );
  end

  // Raw quad bytes travel to the output stage.
  logic [31:0] quad_al;

  psp_delay #(.WIDTH(32), .DEPTH(S_DEG - 1)) u_quad_dly (
    .clk_i  (clk_i),
    .en_i   (en),
    .data_i (quad_q),
    .data_o (quad_al)
  );

  // Output stage: mode selection, colour table and HSV conversion.
  logic [7:0]  deg8, idx, lo, mid, xv;
  logic [39:0] z255;
  logic [34:0] z6;
  logic [2:0]  sector;
  logic [32:0] frac;
  logic [40:0] prod;
  rgb_t        hue;
  psp_out_t    res_d, res_q;

  assign deg8   = dq[DIV_STEPS][DIV_STEPS-1] ? 8'hFF : dq[DIV_STEPS][7:0];
  assign z255   = {z_al, 8'b0} - {8'b0, z_al};
  assign idx    = z255[39:32];
  assign hue    = hue_ramp(idx);
  assign z6     = {1'b0, z_al, 2'b0} + {2'b0, z_al, 1'b0};
  assign sector = z6[34:32];
  assign frac   = sector[0] ? (33'h100000000 - {1'b0, z6[31:0]}) : {1'b0, z6[31:0]};
  assign prod   = 41'(deg8) * 41'(frac);
  assign xv     = prod[39:32];
  assign lo     = 8'hFF - deg8;
  assign mid    = xv + lo;

  always_comb begin
    res_d = '0;
    unique case (mode_e'(mode_q))
      MODE_ANGLE: begin
        res_d.byte_a     = hue.b;
        res_d.byte_b     = hue.g;
        res_d.byte_c     = hue.r;
        res_d.bytes_used = 3'd3;
      end
      MODE_DEGREE: begin
        res_d.byte_a     = deg8;
        res_d.bytes_used = 3'd1;
      end
      MODE_HSV: begin
        res_d.bytes_used = 3'd3;
        unique case (sector)
          3'd0: begin
            res_d.byte_a = lo;    res_d.byte_b = mid;   res_d.byte_c = 8'hFF;
          end
          3'd1: begin
            res_d.byte_a = lo;    res_d.byte_b = 8'hFF; res_d.byte_c = mid;
          end
          3'd2: begin
            res_d.byte_a = mid;   res_d.byte_b = 8'hFF; res_d.byte_c = lo;
          end
          3'd3: begin
            res_d.byte_a = 8'hFF; res_d.byte_b = mid;   res_d.byte_c = lo;
          end
          3'd4: begin
            res_d.byte_a = 8'hFF; res_d.byte_b = lo;    res_d.byte_c = mid;
          end
          default: begin
            res_d.byte_a = mid;   res_d.byte_b = lo;    res_d.byte_c = 8'hFF;
          end
        endcase
      end
      default: begin
        res_d.byte_a     = quad_al[31:24];
        res_d.byte_b     = quad_al[23:16];
        res_d.byte_c     = quad_al[15:8];
        res_d.byte_d     = quad_al[7:0];
        res_d.bytes_used = 3'd4;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

  // An accepted transaction enters the first stage.
  `PSP_ASSERT_NEXT(a_enter, in_valid_i && in_ready_o, valid_q[0],
                   "accepted group did not enter the pipeline")
  // A result appears only from the last pipeline stage.
  `PSP_ASSERT_NOW(a_origin, $rose(out_valid_o), $past(valid_q[S_DEG-1]),
                  "result appeared without a group at the last stage")
  // Quad results carry all four bytes.
  `PSP_ASSERT_NOW(a_quad, out_valid_o && mode_q == MODE_QUAD,
                  out_data_o.bytes_used == 3'd4, "quad result with wrong byte count")

endmodule

/* src/psp_delay.sv */
// Stallable delay line that keeps side data in step with the pipeline.
module psp_delay import psp_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WIDTH-1:0] data_i,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] tap_q [DEPTH];

  // Shift one place on every pipeline advance.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= data_i;
      for (int i = 1; i < DEPTH; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
  end

  assign data_o = tap_q[DEPTH-1];

endmodule

/* src/psp_cordic_cell.sv */
// One vectoring rotation of the angle CORDIC.
module psp_cordic_cell import psp_pkg::*; #(
  parameter int unsigned XW    = 36,
  parameter int unsigned STAGE = 0
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic [31:0]          z_i,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic [31:0]          z_o
);

  logic signed [XW-1:0] x_d, y_d, dx, dy;
  logic [31:0]          z_d, atan;

  assign dx   = y_i >>> STAGE;
  assign dy   = x_i >>> STAGE;
  assign atan = cordic_atan(STAGE);

  // Rotate toward the x axis and accumulate the angle.
  always_comb begin
    if (y_i > 0) begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + atan;
    end else begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - atan;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o <= x_d;
      y_o <= y_d;
      z_o <= z_d;
    end
  end

endmodule

/* src/psp_sqrt_cell.sv */
// One result bit of the digit-by-digit integer square root.
module psp_sqrt_cell import psp_pkg::*; #(
  parameter int unsigned VW  = 61,
  parameter int unsigned RB  = 31,
  parameter int unsigned BIT = 0
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [VW-1:0] rem_i,
  input  logic [RB-1:0] root_i,
  output logic [VW-1:0] rem_o,
  output logic [RB-1:0] root_o
);

  localparam int unsigned TW = VW + 2;

  logic [TW-1:0] trial;
  logic          take;

  // (root + 2^BIT)^2 - root^2 against what is left of the radicand.
  assign trial = (TW'(root_i) << (BIT + 1)) + (TW'(1) << (2 * BIT));
  assign take  = TW'(rem_i) >= trial;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= take ? (rem_i - trial[VW-1:0]) : rem_i;
      root_o <= take ? (root_i | (RB'(1) << BIT)) : root_i;
    end
  end

endmodule

/* src/psp_div_cell.sv */
// One quotient bit of the restoring degree divider.
module psp_div_cell import psp_pkg::*; #(
  parameter int unsigned NW  = 51,
  parameter int unsigned DW  = 43,
  parameter int unsigned BIT = 0
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [NW-1:0]        rem_i,
  input  logic [DW-1:0]        den_i,
  input  logic [DIV_STEPS-1:0] q_i,
  output logic [NW-1:0]        rem_o,
  output logic [DW-1:0]        den_o,
  output logic [DIV_STEPS-1:0] q_o
);

  localparam int unsigned CW = NW + DW + DIV_STEPS;

  logic [CW-1:0] shifted;
  logic          take;

  assign shifted = CW'(den_i) << BIT;
  assign take    = CW'(rem_i) >= shifted;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= take ? (rem_i - shifted[NW-1:0]) : rem_i;
      den_o <= den_i;
      q_o   <= take ? (q_i | (DIV_STEPS'(1) << BIT)) : q_i;
    end
  end

endmodule
